/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/psa_pkg.sv */
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants of the per-channel sample averager.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int SMP_W  = 12;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 32;
  localparam int ACT_W  = 5;
  localparam int CH_W   = 4;

  // quotient bits plus one overflow bit
  localparam int DIV_STEPS = SMP_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int DSH_W     = CNT_W + SMP_W;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);
  localparam logic [SMP_W-1:0] AVG_MAX   = {SMP_W{1'b1}};

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic [SMP_W-1:0] average;
    logic             bad_channel;
  } out_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } entry_t;

endpackage

/* rtl/per_channel_sample_averager_core.sv */
// ----------------------------------------------------------------------------
// per_channel_sample_averager_core
// Running sum and sample count per converter channel, held in one entry
// memory; add requests accumulate, read requests return sum / count and
// clear the channel.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_req     | operation, channel, sample
//  out     | out_valid, out_stall, out_req  | average, bad_channel
//  cfg     | cfg_we, cfg_wdata              | active_channels
//
//  Add: memory read, then modify and write back.
//  Read: memory read and entry clear, then 13 restoring-divider steps, then hand-over.
//  Bad channel: an add is dropped after the lookup; a read hands over a zero result.
//  Reset clears the entry valid bits; an invalid entry reads as zero.
//  A stalled result holds in the output register; in_stall rises while busy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_channel_sample_averager_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  psa_pkg::in_req_t            in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output psa_pkg::out_req_t           out_req,
  input  logic                        cfg_we,
  input  logic [psa_pkg::ACT_W-1:0]   cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  psa_pkg::entry_t mem [psa_pkg::MAX_CHANNELS];
  psa_pkg::entry_t rd_r;

  logic [1:0]                      state_r, state_nxt;
  logic [psa_pkg::ACT_W-1:0]       act_r;
  logic [psa_pkg::MAX_CHANNELS-1:0] vld_r, vld_nxt;
  logic                            hit_r;

  logic                            op_r, op_nxt;
  logic                            bad_r, bad_nxt;
  logic [psa_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [psa_pkg::SMP_W-1:0]       smp_r, smp_nxt;

  logic [psa_pkg::SUM_W-1:0]       rem_r, rem_nxt;
  logic [psa_pkg::DSH_W-1:0]       dsh_r, dsh_nxt;
  logic [psa_pkg::DIV_STEPS-1:0]   q_r, q_nxt;
  logic [psa_pkg::STEP_W-1:0]      step_r, step_nxt;

  logic                            out_valid_r, out_valid_nxt;
  psa_pkg::out_req_t               out_req_r, out_req_nxt;

  logic                            in_acc;
  logic                            in_use;
  logic [psa_pkg::ADDR_W-1:0]      in_addr;
  logic                            mem_re;
  logic                            mem_we;
  psa_pkg::entry_t                 mem_wd;
  psa_pkg::entry_t                 cur;
  logic [psa_pkg::SUM_W-1:0]       sum_add;
  logic [psa_pkg::CNT_W-1:0]       cnt_add;
  logic [psa_pkg::DSH_W-1:0]       rem_ext;
  logic                            ge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_use    = ({1'b0, in_req.channel} < act_r)
                  && (int'(in_req.channel) < psa_pkg::MAX_CHANNELS);
  assign in_addr   = psa_pkg::ADDR_W'(in_req.channel);
  assign mem_re    = in_acc && in_use;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  assign cur     = hit_r ? rd_r : '0;
  assign sum_add = cur.sum + psa_pkg::SUM_W'(smp_r);
  assign cnt_add = (&cur.count) ? cur.count : cur.count + psa_pkg::CNT_W'(1);
  assign rem_ext = psa_pkg::DSH_W'(rem_r);
  assign ge      = (rem_ext >= dsh_r);

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    op_nxt        = op_r;
    bad_nxt       = bad_r;
    addr_nxt      = addr_r;
    smp_nxt       = smp_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;
    mem_we        = 1'b0;
    mem_wd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_req.operation;
          bad_nxt   = !in_use;
          addr_nxt  = in_addr;
          smp_nxt   = in_req.sample_value;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (bad_r) begin
          q_nxt     = '0;
          state_nxt = (op_r == psa_pkg::OP_READ) ? S_PUT : S_IDLE;
        end else if (op_r == psa_pkg::OP_ADD) begin
          mem_we = 1'b1;
          if (sum_add[psa_pkg::SUM_W-1]) begin
            mem_wd.sum   = sum_add >> 1;
            mem_wd.count = cnt_add >> 1;
          end else begin
            mem_wd.sum   = sum_add;
            mem_wd.count = cnt_add;
          end
          vld_nxt[addr_r] = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          // read clears the entry; the divider keeps its own copy
          mem_we          = 1'b1;
          vld_nxt[addr_r] = 1'b1;
          rem_nxt   = cur.sum;
          dsh_nxt   = {((cur.count == '0) ? psa_pkg::CNT_W'(1) : cur.count),
                       {psa_pkg::SMP_W{1'b0}}};
          q_nxt     = '0;
          step_nxt  = psa_pkg::STEP_W'(psa_pkg::DIV_STEPS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - psa_pkg::SUM_W'(dsh_r);
        end
        q_nxt   = {q_r[psa_pkg::DIV_STEPS-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        if (step_r == '0) begin
          state_nxt = S_PUT;
        end else begin
          step_nxt = step_r - psa_pkg::STEP_W'(1);
        end
      end
      S_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_req_nxt.bad_channel = bad_r;
          if (bad_r) begin
            out_req_nxt.average = '0;
          end else if (q_r[psa_pkg::DIV_STEPS-1]) begin
            out_req_nxt.average = psa_pkg::AVG_MAX;
          end else begin
            out_req_nxt.average = q_r[psa_pkg::SMP_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= psa_pkg::ACT_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    bad_r     <= bad_nxt;
    addr_r    <= addr_nxt;
    smp_r     <= smp_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    q_r       <= q_nxt;
    step_r    <= step_nxt;
    out_req_r <= out_req_nxt;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wd;
    end
    if (mem_re) begin
      rd_r  <= mem[in_addr];
      hit_r <= vld_r[in_addr];
    end
  end

  `PSA_ASSERT_NXT(a_acc_look, in_acc, state_r == S_LOOK)
  `PSA_ASSERT_IMP(a_bad_zero, out_valid && out_req.bad_channel, out_req.average == '0)
  `PSA_ASSERT_IMP(a_step_rng, state_r == S_DIV,
    step_r <= psa_pkg::STEP_W'(psa_pkg::DIV_STEPS - 1))
  `PSA_ASSERT_NXT(a_wr_vld, mem_we, vld_r[$past(addr_r)])

endmodule

/* bench/tb_per_channel_sample_averager_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_channel_sample_averager_core
// Self-checking bench: a clocked driver feeds add and read requests from a
// queue, and a clocked monitor runs a channel-by-channel sum/count model on
// every accepted request and compares each result with the oldest predicted
// average. Directed cases come first, then a short add run on one channel
// closed by a read, then random add/read sequences under several channel
// counts. Random gaps and stalls are applied on both sides in most random phases.
// ----------------------------------------------------------------------------
module tb_per_channel_sample_averager_core;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RUN_LIMIT_NS  = 10_000_000;
  localparam int unsigned ADD_RUN_LEN   = 40;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned BATCH_ITEMS   = 180;
  localparam logic [psa_pkg::SUM_W-1:0] SUM_LIMIT = 32'h8000_0000;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  psa_pkg::in_req_t          in_req    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  psa_pkg::out_req_t         out_req;
  logic                      cfg_we    = 1'b0;
  logic [psa_pkg::ACT_W-1:0] cfg_wdata = '0;

  psa_pkg::in_req_t          queued_requests[$];
  psa_pkg::out_req_t         pending_averages[$];
  logic [psa_pkg::SUM_W-1:0] chan_sum   [psa_pkg::MAX_CHANNELS];
  logic [psa_pkg::CNT_W-1:0] chan_count [psa_pkg::MAX_CHANNELS];
  logic [psa_pkg::ACT_W-1:0] active_chans = psa_pkg::ACT_RESET;
  logic [psa_pkg::ACT_W-1:0] phase_active = psa_pkg::ACT_RESET;
  int unsigned mismatch_count = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  logic        send_pause_en  = 1'b0;
  logic        sink_pause_en  = 1'b0;

  per_channel_sample_averager_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [psa_pkg::SMP_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return psa_pkg::AVG_MAX;
    return psa_pkg::SMP_W'($urandom);
  endfunction

  // sum/count model of one accepted request
  task automatic track_request(input psa_pkg::in_req_t r);
    psa_pkg::out_req_t         res;
    logic [psa_pkg::CNT_W-1:0] divisor;
    logic [psa_pkg::SUM_W-1:0] quotient;
    logic                      in_use;
    in_use = (r.channel < active_chans) && (r.channel < psa_pkg::MAX_CHANNELS);
    if (r.operation == psa_pkg::OP_ADD) begin
      if (in_use) begin
        chan_sum[r.channel] = chan_sum[r.channel] + r.sample_value;
        if (chan_count[r.channel] != '1) chan_count[r.channel] = chan_count[r.channel] + 1;
        if (chan_sum[r.channel] >= SUM_LIMIT) begin
          chan_sum[r.channel]   = chan_sum[r.channel] >> 1;
          chan_count[r.channel] = chan_count[r.channel] >> 1;
        end
      end
    end else begin
      if (!in_use) begin
        res.average     = '0;
        res.bad_channel = 1'b1;
      end else begin
        divisor  = (chan_count[r.channel] != 0) ? chan_count[r.channel] : 1;
        quotient = chan_sum[r.channel] / divisor;
        res.average     = (quotient > psa_pkg::AVG_MAX) ? psa_pkg::AVG_MAX
                                                        : quotient[psa_pkg::SMP_W-1:0];
        res.bad_channel = 1'b0;
        chan_sum[r.channel]   = '0;
        chan_count[r.channel] = '0;
      end
      pending_averages.push_back(res);
    end
  endtask

  task automatic note_mismatch(input string what, input psa_pkg::out_req_t want,
                               input psa_pkg::out_req_t got);
    if (mismatch_count < REPORT_LIMIT)
      $display("%0t: %s: expected average %0d bad %0b, got average %0d bad %0b",
               $time, what, want.average, want.bad_channel, got.average, got.bad_channel);
    mismatch_count++;
  endtask

  task automatic check_result(input psa_pkg::out_req_t got);
    psa_pkg::out_req_t want;
    if (pending_averages.size() == 0) begin
      note_mismatch("result with no read waiting", '0, got);
    end else begin
      want = pending_averages.pop_front();
      if (got.average !== want.average) note_mismatch("average mismatch", want, got);
      else if (got.bad_channel !== want.bad_channel)
        note_mismatch("bad_channel mismatch", want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_requests.size() != 0) begin
        in_req   <= queued_requests.pop_front();
        in_valid <= 1'b1;
        gap_left <= send_pause_en ? pick_pause() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor, model and result stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      active_chans  = psa_pkg::ACT_RESET;
      for (int i = 0; i < psa_pkg::MAX_CHANNELS; i++) begin
        chan_sum[i]   = '0;
        chan_count[i] = '0;
      end
    end else begin
      if (cfg_we) active_chans = cfg_wdata;
      if (in_valid && !in_stall) track_request(in_req);
      if (out_valid && !out_stall) check_result(out_req);
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (sink_pause_en && $urandom_range(0, 2) == 0) stall_left <= pick_pause();
      end
    end
  end

  task automatic push_req(input logic op, input logic [psa_pkg::CH_W-1:0] ch,
                          input logic [psa_pkg::SMP_W-1:0] smp);
    psa_pkg::in_req_t r;
    r.operation    = op;
    r.channel      = ch;
    r.sample_value = smp;
    while (queued_requests.size() >= 64) @(negedge clk);
    queued_requests.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || pending_averages.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_active(input logic [psa_pkg::ACT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phase_active = v;
  endtask

  // mostly add runs closed by a read, the rest stray requests
  task automatic push_random_batch(input int unsigned n_items);
    int unsigned               placed;
    int unsigned               n_adds;
    int unsigned               lim;
    logic [psa_pkg::CH_W-1:0]  ch;
    logic                      op;
    placed = 0;
    lim = (phase_active > psa_pkg::MAX_CHANNELS) ? psa_pkg::MAX_CHANNELS : phase_active;
    while (placed < n_items) begin
      if (lim == 0 || $urandom_range(0, 4) == 0) begin
        ch = psa_pkg::CH_W'($urandom_range(0, 15));
        op = 1'($urandom_range(0, 1));
        push_req(op, ch, pick_sample());
        if (op == psa_pkg::OP_READ || ch < lim) placed++;
      end else begin
        ch = psa_pkg::CH_W'($urandom_range(0, lim - 1));
        n_adds = $urandom_range(0, 8);
        repeat (n_adds) push_req(psa_pkg::OP_ADD, ch, pick_sample());
        push_req(psa_pkg::OP_READ, ch, psa_pkg::SMP_W'($urandom));
        placed += n_adds + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, no idling
    push_req(psa_pkg::OP_READ, 0, 0);
    push_req(psa_pkg::OP_ADD, 15, psa_pkg::AVG_MAX);
    push_req(psa_pkg::OP_READ, 15, psa_pkg::AVG_MAX);
    push_req(psa_pkg::OP_ADD, 0, 0);
    push_req(psa_pkg::OP_ADD, 0, psa_pkg::AVG_MAX);
    push_req(psa_pkg::OP_READ, 0, 0);
    push_req(psa_pkg::OP_ADD, 5, 12'hAAA);
    push_req(psa_pkg::OP_ADD, 5, 12'h555);
    push_req(psa_pkg::OP_READ, 5, 12'h555);
    push_req(psa_pkg::OP_ADD, 10, 1);
    push_req(psa_pkg::OP_ADD, 10, 2);
    push_req(psa_pkg::OP_READ, 10, 0);
    wait_idle();

    write_active(1);
    push_req(psa_pkg::OP_READ, 1, 0);
    push_req(psa_pkg::OP_ADD, 1, 100);
    push_req(psa_pkg::OP_ADD, 0, 7);
    push_req(psa_pkg::OP_READ, 0, 0);
    wait_idle();

    write_active(0);
    push_req(psa_pkg::OP_READ, 0, 0);
    push_req(psa_pkg::OP_ADD, 0, 5);
    push_req(psa_pkg::OP_READ, 15, 0);
    wait_idle();

    write_active(31);
    push_req(psa_pkg::OP_ADD, 15, 300);
    push_req(psa_pkg::OP_READ, 15, 0);
    push_req(psa_pkg::OP_READ, 10, 0);

    // add run on one channel, closed by a read
    for (int n = 0; n < ADD_RUN_LEN; n++) push_req(psa_pkg::OP_ADD, 2, psa_pkg::AVG_MAX);
    push_req(psa_pkg::OP_ADD, 2, 17);
    push_req(psa_pkg::OP_READ, 2, 0);
    wait_idle();

    // random phases
    send_pause_en = 1'b1;
    sink_pause_en = 1'b1;
    write_active(16);
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    write_active(1);
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    send_pause_en = 1'b0;
    write_active(31);
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    send_pause_en = 1'b1;
    sink_pause_en = 1'b0;
    write_active(7);
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    sink_pause_en = 1'b1;
    write_active(0);
    push_random_batch(60);
    wait_idle();

    write_active(psa_pkg::ACT_W'($urandom_range(2, 15)));
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    send_pause_en = 1'b0;
    sink_pause_en = 1'b0;
    write_active(16);
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    send_pause_en = 1'b1;
    sink_pause_en = 1'b1;
    write_active(psa_pkg::ACT_W'($urandom_range(0, 31)));
    push_random_batch(BATCH_ITEMS);
    wait_idle();

    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("** per_channel_sample_averager_core: PASSED **");
    end else begin
      $display("** per_channel_sample_averager_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** per_channel_sample_averager_core: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/psa_pkg.sv
rtl/per_channel_sample_averager_core.sv
bench/tb_per_channel_sample_averager_core.sv
